/* src/rbc_pkg.sv */
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types and codes of the range boundary compiler: payload structs,
// command and status codes, and the controller to datapath command set.
// ----------------------------------------------------------------------------
package rbc_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_READ  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_code_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] range_from;
    logic [31:0] range_to;
    logic [31:0] range_label;
    logic [8:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  coord_count;
    logic [31:0] coordinate;
    logic [8:0]  open_count;
    logic [9:0]  first_interval;
    logic [9:0]  interval_count;
    logic        group_start;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REJECT,
    OP_BUILD_START,
    OP_BUILD_RUN,
    OP_READ_START,
    OP_READ_DONE,
    OP_QUERY_START,
    OP_QUERY_CAP,
    OP_QUERY_GRP,
    OP_QUERY_RUN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_bad;
    logic q_bad;
    logic build_fin;
    logic scan_end;
  } dp_stat_t;

endpackage

/* src/rbc_ctrl.sv */
// ----------------------------------------------------------------------------
// rbc_ctrl
// Command sequencer: accepts one item at a time, steps the datapath through
// load, build, read and query, and owns the output valid flag.
// ----------------------------------------------------------------------------
module rbc_ctrl import rbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_READ,
    S_QCAP,
    S_QGRP,
    S_QRUN
  } state_t;

  state_t state, state_next;
  logic   slot_free;
  logic   accept;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !(state == S_IDLE && slot_free);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_code_t'(in_cmd))
            CMD_LOAD: begin
              cmd.op       = OP_LOAD;
              cmd.out_load = 1'b1;
            end
            CMD_BUILD: begin
              cmd.op     = OP_BUILD_START;
              state_next = S_BUILD;
            end
            CMD_READ: begin
              if (stat.rd_bad) begin
                cmd.op       = OP_REJECT;
                cmd.out_load = 1'b1;
              end else begin
                cmd.op     = OP_READ_START;
                state_next = S_READ;
              end
            end
            CMD_QUERY: begin
              if (stat.q_bad) begin
                cmd.op       = OP_REJECT;
                cmd.out_load = 1'b1;
              end else begin
                cmd.op     = OP_QUERY_START;
                state_next = S_QCAP;
              end
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      S_BUILD: begin
        cmd.op = OP_BUILD_RUN;
        if (stat.build_fin) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_READ: begin
        cmd.op       = OP_READ_DONE;
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      S_QCAP: begin
        cmd.op     = OP_QUERY_CAP;
        state_next = S_QGRP;
      end
      S_QGRP: begin
        cmd.op     = OP_QUERY_GRP;
        state_next = S_QRUN;
      end
      S_QRUN: begin
        cmd.op = OP_QUERY_RUN;
        if (stat.scan_end) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a result is only loaded into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> slot_free)
    else $error("result loaded over a pending result");

  // nothing is taken while an item is still being worked on
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input open while busy");

  // a new result appears only from an accepted item or a finishing sequence
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (accept || state != S_IDLE))
    else $error("result without an item");

endmodule

/* src/rbc_datapath.sv */
// ----------------------------------------------------------------------------
// rbc_datapath
// Range store, coordinate table, scan counter and compare logic. A build
// scans the store once, then once per coordinate; a query scans the table.
// ----------------------------------------------------------------------------
module rbc_datapath import rbc_pkg::*; #(
  parameter int MAX_RANGES = 256,
  parameter int KEY_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_item
);

  localparam int RW = $clog2(MAX_RANGES + 1);
  localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int DW = $clog2(2 * MAX_RANGES + 1);
  localparam int CW = $clog2(2 * MAX_RANGES);
  localparam int PD = 2 * MAX_RANGES;
  localparam logic [KEY_WIDTH-1:0] KMAX = {KEY_WIDTH{1'b1}};

  logic [KEY_WIDTH-1:0] s_from  [MAX_RANGES];
  logic [KEY_WIDTH-1:0] s_to    [MAX_RANGES];
  logic [31:0]          s_label [MAX_RANGES];
  logic [KEY_WIDTH-1:0] coord_mem [PD];
  logic [RW-1:0]        open_mem  [PD];

  logic [RW-1:0] range_total;
  logic [DW-1:0] distinct_total;
  logic          built;

  logic [KEY_WIDTH-1:0] rd_from, rd_to, rd_coord;
  logic [31:0]          rd_label;
  logic [RW-1:0]        rd_open;
  logic [IW-1:0]        s_addr;
  logic [CW-1:0]        c_addr;

  // scan state
  logic [DW-1:0] sc;
  logic          pipe_v;
  logic          run;
  logic          issue;
  logic          scan_end;
  logic [DW-1:0] lim;

  // build state
  logic [KEY_WIDTH-1:0] cur, min_key;
  logic                 first, found, invalid;
  logic [RW-1:0]        cnt;
  logic [DW-1:0]        k, k_next;

  // query state
  logic [KEY_WIDTH-1:0] lo, hi;
  logic [31:0]          lab;
  logic [IW-1:0]        q_idx;
  logic                 q_zero, grp;
  logic [DW-1:0]        p, c;

  // load
  logic [RW-1:0] base;
  logic          full;

  // per element compare
  logic [KEY_WIDTH-1:0] c2, cand;
  logic                 c1_v, c2_v, cand_v, hit;

  out_item_t res;

  assign base = built ? '0 : range_total;
  assign full = base >= RW'(MAX_RANGES);

  assign stat.rd_bad = !built || (32'(in_item.entry_index) >= 32'(distinct_total));
  assign stat.q_bad  = !built || (32'(in_item.entry_index) >= 32'(range_total));

  assign run      = (cmd.op == OP_BUILD_RUN) || (cmd.op == OP_QUERY_RUN);
  assign lim      = (cmd.op == OP_QUERY_RUN) ? distinct_total : DW'(range_total);
  assign issue    = run && (sc < lim);
  assign scan_end = !issue && !pipe_v;
  assign k_next   = first ? k : k + 1'b1;

  assign stat.scan_end  = scan_end;
  assign stat.build_fin = (cmd.op == OP_BUILD_RUN) && scan_end && (invalid || !found);

  always_comb begin
    case (cmd.op)
      OP_QUERY_START: s_addr = IW'(in_item.entry_index);
      OP_QUERY_CAP:   s_addr = q_idx - 1'b1;
      default:        s_addr = IW'(sc);
    endcase
    c_addr = (cmd.op == OP_READ_START) ? CW'(in_item.entry_index) : CW'(sc);
  end

  // candidate for the next coordinate above cur
  always_comb begin
    c1_v = rd_from > cur;
    c2_v = (rd_to >= cur) && (rd_to != KMAX);
    c2   = rd_to + 1'b1;
    hit  = !first && (rd_from <= cur) && (rd_to >= cur);
    if (first) begin
      cand_v = 1'b1;
      cand   = rd_from;
    end else if (c1_v && c2_v) begin
      cand_v = 1'b1;
      cand   = (rd_from < c2) ? rd_from : c2;
    end else if (c1_v) begin
      cand_v = 1'b1;
      cand   = rd_from;
    end else begin
      cand_v = c2_v;
      cand   = c2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && !full) begin
      s_from[IW'(base)]  <= KEY_WIDTH'(in_item.range_from);
      s_to[IW'(base)]    <= KEY_WIDTH'(in_item.range_to);
      s_label[IW'(base)] <= in_item.range_label;
    end
    rd_from  <= s_from[s_addr];
    rd_to    <= s_to[s_addr];
    rd_label <= s_label[s_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_BUILD_RUN && scan_end && !invalid && !first) begin
      coord_mem[CW'(k)] <= cur;
      open_mem[CW'(k)]  <= cnt;
    end
    rd_coord <= coord_mem[c_addr];
    rd_open  <= open_mem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      range_total    <= '0;
      distinct_total <= '0;
      built          <= 1'b0;
      sc             <= '0;
      pipe_v         <= 1'b0;
      first          <= 1'b1;
      found          <= 1'b0;
      invalid        <= 1'b0;
      k              <= '0;
      cnt            <= '0;
    end else begin
      pipe_v <= issue;
      if (issue) begin
        sc <= sc + 1'b1;
      end
      case (cmd.op)
        OP_LOAD: begin
          range_total    <= full ? base : base + 1'b1;
          distinct_total <= '0;
          built          <= 1'b0;
        end
        OP_BUILD_START: begin
          built          <= 1'b0;
          distinct_total <= '0;
          sc             <= '0;
          pipe_v         <= 1'b0;
          first          <= 1'b1;
          found          <= 1'b0;
          invalid        <= 1'b0;
          k              <= '0;
          cnt            <= '0;
        end
        OP_BUILD_RUN: begin
          if (pipe_v) begin
            if (rd_from > rd_to) begin
              invalid <= 1'b1;
            end
            if (hit) begin
              cnt <= cnt + 1'b1;
            end
            if (cand_v && (!found || cand < min_key)) begin
              min_key <= cand;
              found   <= 1'b1;
            end
          end
          if (scan_end && !invalid) begin
            k <= k_next;
            if (found) begin
              // next pass on the smallest point above cur
              cur   <= min_key;
              first <= 1'b0;
              found <= 1'b0;
              cnt   <= '0;
              sc    <= '0;
            end else begin
              built          <= 1'b1;
              distinct_total <= k_next;
            end
          end
        end
        OP_QUERY_START: begin
          q_idx  <= IW'(in_item.entry_index);
          q_zero <= in_item.entry_index == 9'd0;
        end
        OP_QUERY_CAP: begin
          lo  <= rd_from;
          hi  <= rd_to;
          lab <= rd_label;
        end
        OP_QUERY_GRP: begin
          grp    <= q_zero || (rd_label != lab);
          sc     <= '0;
          pipe_v <= 1'b0;
          p      <= '0;
          c      <= '0;
        end
        OP_QUERY_RUN: begin
          if (pipe_v) begin
            if (rd_coord < lo) begin
              p <= p + 1'b1;
            end else if (rd_coord <= hi) begin
              c <= c + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res             = '0;
    res.coord_count = 10'(distinct_total);
    case (cmd.op)
      OP_LOAD: begin
        res.status      = full ? ST_OVERFLOW : ST_OK;
        res.coord_count = '0;
      end
      OP_REJECT: res.status = ST_BAD;
      OP_BUILD_RUN: begin
        res.status      = invalid ? ST_INVALID : ST_OK;
        res.coord_count = invalid ? 10'd0 : 10'(k_next);
      end
      OP_READ_DONE: begin
        res.coordinate = 32'(rd_coord);
        res.open_count = 9'(rd_open);
      end
      OP_QUERY_RUN: begin
        res.first_interval = (c != '0) ? 10'(p + 1'b1) : 10'd0;
        res.interval_count = 10'(c);
        res.group_start    = grp;
      end
      default: res.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item <= res;
    end
  end

  a_table_needs_build: assert property (@(posedge clk) disable iff (rst)
    (distinct_total != '0) |-> built)
    else $error("coordinate count without a built table");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    range_total <= RW'(MAX_RANGES))
    else $error("range count beyond store depth");

  a_pipe_from_run: assert property (@(posedge clk) disable iff (rst)
    pipe_v |-> $past(issue))
    else $error("scan data without a read");

  a_coord_bound: assert property (@(posedge clk) disable iff (rst)
    k <= DW'(PD))
    else $error("coordinate write index beyond table");

endmodule

/* src/range_boundary_compiler_unit.sv */
// ----------------------------------------------------------------------------
// range_boundary_compiler_unit
// Elementary interval decomposition of labelled key ranges.
// ----------------------------------------------------------------------------
// One input channel (in_valid / in_stall / in_item) takes commands: load,
// build, read boundary entry and query range. One output channel
// (out_valid / out_stall / out_item) gives exactly one result per command.
// A transfer happens on a clock edge with valid high and stall low.
// Items are worked one at a time; the next is taken once the result slot
// is free, so a stalled receiver holds off the input and the held result
// stays unchanged. With no stall, loads and rejected commands run one per
// cycle; any other command blocks the input until its result is loaded.
// A build reads the range store through its single read port, scanning it
// once to find the lowest key and once more for every coordinate produced;
// a query scans the coordinate table once.
// Reset (rst, synchronous) empties the store and drops any built table;
// memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module range_boundary_compiler_unit import rbc_pkg::*; #(
  parameter int MAX_RANGES = 256,
  parameter int KEY_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_cmd    (in_item.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbc_datapath #(
    .MAX_RANGES (MAX_RANGES),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
